>>> hw/rtl/mipmap_box_downsample_2x2_core_assert.svh
// Assertion macros used by the checker file of the downsampler.
`ifndef MIPMAP_BOX_DOWNSAMPLE_2X2_CORE_ASSERT_SVH
`define MIPMAP_BOX_DOWNSAMPLE_2X2_CORE_ASSERT_SVH

// The check is skipped while the reset is active.
`define MBD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The check also runs while the reset is active.
`define MBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/mbd_pkg.sv
// Shared constants, types and helpers of the 2x2 box-filter downsampler.
package mbd_pkg;

  localparam int unsigned MAX_WIDTH_DEFAULT = 2048;
  localparam int unsigned HEIGHT_LIMIT      = 2048;
  localparam int unsigned RESET_SIZE        = 2048;

  localparam int unsigned CH_W       = 8;
  localparam int unsigned SUM_W      = CH_W + 1;
  localparam int unsigned QUAD_W     = 4 * SUM_W;
  localparam int unsigned CNT_W      = 12;
  localparam int unsigned ROW_W      = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned OPQ_DEPTH  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_PIXEL_FORMAT = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    FMT_RGBA = 1'b0,
    FMT_RGB  = 1'b1
  } pix_fmt_e;

  typedef logic [3:0][CH_W-1:0]  pixel_t;
  typedef logic [3:0][SUM_W-1:0] sum_quad_t;

  typedef struct packed {
    logic is_read;
    logic eor;
    logic eoi;
    logic rgb;
  } op_flags_t;

  function automatic int unsigned line_addr_w(int unsigned max_width);
    int unsigned depth;
    depth = max_width >> 1;
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

>>> hw/rtl/mbd_pix_if.sv
// Valid/ready channel interfaces for source pixels and downsampled pixels.
interface mbd_pix_in_if;
  logic       valid;
  logic       ready;
  logic       start_of_image;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;

  modport source (
    output valid, start_of_image, red_in, green_in, blue_in, alpha_in,
    input  ready
  );
  modport sink (
    input  valid, start_of_image, red_in, green_in, blue_in, alpha_in,
    output ready
  );
endinterface

interface mbd_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  logic       end_of_row;
  logic       end_of_image;

  modport source (
    output valid, red_out, green_out, blue_out, alpha_out, end_of_row, end_of_image,
    input  ready
  );
  modport sink (
    input  valid, red_out, green_out, blue_out, alpha_out, end_of_row, end_of_image,
    output ready
  );
endinterface

>>> hw/rtl/mbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mbd_ram #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

>>> hw/rtl/mbd_op_fifo.sv
// Short operation queue between the pixel front end and the line-buffer back end.
module mbd_op_fifo #(
  parameter int unsigned SLOT_W = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  mbd_pkg::op_flags_t    push_flags_i,
  input  logic [SLOT_W-1:0]     push_slot_i,
  input  mbd_pkg::sum_quad_t    push_pair_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output mbd_pkg::op_flags_t    pop_flags_o,
  output logic [SLOT_W-1:0]     pop_slot_o,
  output mbd_pkg::sum_quad_t    pop_pair_o
);
  import mbd_pkg::*;

  localparam int unsigned PTR_W = (OPQ_DEPTH > 1) ? $clog2(OPQ_DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(OPQ_DEPTH + 1);

  op_flags_t         flags_q [OPQ_DEPTH];
  logic [SLOT_W-1:0] slot_q  [OPQ_DEPTH];
  sum_quad_t         pair_q  [OPQ_DEPTH];
  logic [PTR_W-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_QW-1:0] count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != CNT_QW'(OPQ_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  assign pop_flags_o = flags_q[rptr_q];
  assign pop_slot_o  = slot_q[rptr_q];
  assign pop_pair_o  = pair_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = (wptr_q == PTR_W'(OPQ_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == PTR_W'(OPQ_DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_QW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      flags_q[wptr_q] <= push_flags_i;
      slot_q[wptr_q]  <= push_slot_i;
      pair_q[wptr_q]  <= push_pair_i;
    end
  end
endmodule

>>> hw/rtl/mbd_front.sv
// Front end: configuration registers, raster counters, pair sums and operation issue.
module mbd_front #(
  parameter int unsigned MAX_WIDTH = mbd_pkg::MAX_WIDTH_DEFAULT,
  parameter int unsigned SLOT_W = mbd_pkg::line_addr_w(MAX_WIDTH)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mbd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mbd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  mbd_pix_in_if.sink                       pix_i,
  output logic                             op_valid_o,
  input  logic                             op_ready_i,
  output mbd_pkg::op_flags_t               op_flags_o,
  output logic [SLOT_W-1:0]                op_slot_o,
  output mbd_pkg::sum_quad_t               op_pair_o
);
  import mbd_pkg::*;

  localparam int unsigned WCAP = (MAX_WIDTH > 4095) ? 4095 : MAX_WIDTH;

  logic [CNT_W-1:0] width_q, height_q;
  pix_fmt_e         fmt_q;
  logic [CNT_W-1:0] col_q, col_d, col_cur;
  logic [ROW_W-1:0] row_q, row_d, row_cur;
  pixel_t           left_q, px;
  logic [CNT_W-1:0] w_eff, h_eff, w_last, h_last, even_w, even_h, row_ext;
  logic             in_area, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CNT_W'(RESET_SIZE);
      height_q <= CNT_W'(RESET_SIZE);
      fmt_q    <= FMT_RGBA;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        CFG_PIXEL_FORMAT: fmt_q    <= pix_fmt_e'(cfg_data_i[0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      w_eff = CNT_W'(1);
    end else if (width_q > CNT_W'(WCAP)) begin
      w_eff = CNT_W'(WCAP);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = CNT_W'(1);
    end else if (height_q > CNT_W'(HEIGHT_LIMIT)) begin
      h_eff = CNT_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = height_q;
    end
  end

  assign w_last  = w_eff - CNT_W'(1);
  assign h_last  = h_eff - CNT_W'(1);
  assign even_w  = {w_eff[CNT_W-1:1], 1'b0};
  assign even_h  = {h_eff[CNT_W-1:1], 1'b0};

  assign col_cur = pix_i.start_of_image ? '0 : col_q;
  assign row_cur = pix_i.start_of_image ? '0 : row_q;
  assign row_ext = {{(CNT_W - ROW_W){1'b0}}, row_cur};

  assign px = {pix_i.alpha_in, pix_i.blue_in, pix_i.green_in, pix_i.red_in};

  assign in_area = col_cur[0] && (col_cur < even_w) && (row_ext < even_h);
  assign accept  = pix_i.valid && pix_i.ready;

  assign pix_i.ready = op_ready_i;
  assign op_valid_o  = pix_i.valid && in_area;
  assign op_slot_o   = SLOT_W'(col_cur >> 1);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      op_pair_o[k] = {1'b0, left_q[k]} + {1'b0, px[k]};
    end
    op_flags_o.is_read = row_cur[0];
    op_flags_o.eor     = (col_cur == even_w - CNT_W'(1));
    op_flags_o.eoi     = op_flags_o.eor && (row_ext == even_h - CNT_W'(1));
    op_flags_o.rgb     = (fmt_q == FMT_RGB);
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_cur >= w_last) begin
        col_d = '0;
        row_d = (row_ext >= h_last) ? '0 : row_cur + ROW_W'(1);
      end else begin
        col_d = col_cur + CNT_W'(1);
        row_d = row_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept && !col_cur[0]) begin
        left_q <= px;
      end
    end
  end
endmodule

>>> hw/rtl/mbd_back.sv
// Back end: line-buffer writes and reads, block averaging and the output register.
module mbd_back #(
  parameter int unsigned MAX_WIDTH = mbd_pkg::MAX_WIDTH_DEFAULT,
  parameter int unsigned SLOT_W = mbd_pkg::line_addr_w(MAX_WIDTH)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               op_valid_i,
  output logic               op_ready_o,
  input  mbd_pkg::op_flags_t op_flags_i,
  input  logic [SLOT_W-1:0]  op_slot_i,
  input  mbd_pkg::sum_quad_t op_pair_i,
  mbd_pix_out_if.source      pix_o
);
  import mbd_pkg::*;

  localparam int unsigned LINE_DEPTH = (MAX_WIDTH >> 1);

  logic              pop, s1_adv, s1_free, out_free;
  logic              s1_valid_q, out_valid_q;
  op_flags_t         s1_flags_q;
  sum_quad_t         s1_pair_q, above;
  logic [QUAD_W-1:0] ram_rdata;
  pixel_t            avg_d, out_px_q;
  logic              out_eor_q, out_eoi_q;

  assign out_free   = !out_valid_q || pix_o.ready;
  assign s1_adv     = s1_valid_q && out_free;
  assign s1_free    = !s1_valid_q || s1_adv;
  assign op_ready_o = !op_flags_i.is_read || s1_free;
  assign pop        = op_valid_i && op_ready_o;

  mbd_ram #(
    .WIDTH (QUAD_W),
    .DEPTH (LINE_DEPTH),
    .ADDR_W(SLOT_W)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (pop && !op_flags_i.is_read),
    .waddr_i(op_slot_i),
    .wdata_i(op_pair_i),
    .re_i   (pop && op_flags_i.is_read),
    .raddr_i(op_slot_i),
    .rdata_o(ram_rdata)
  );

  assign above = sum_quad_t'(ram_rdata);

  always_comb begin
    logic [SUM_W:0] tot;
    for (int k = 0; k < 4; k++) begin
      tot      = {1'b0, above[k]} + {1'b0, s1_pair_q[k]};
      avg_d[k] = tot[SUM_W:2];
    end
    if (s1_flags_q.rgb) begin
      avg_d[3] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop && op_flags_i.is_read) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (pix_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && op_flags_i.is_read) begin
      s1_flags_q <= op_flags_i;
      s1_pair_q  <= op_pair_i;
    end
    if (s1_adv) begin
      out_px_q  <= avg_d;
      out_eor_q <= s1_flags_q.eor;
      out_eoi_q <= s1_flags_q.eoi;
    end
  end

  assign pix_o.valid        = out_valid_q;
  assign pix_o.red_out      = out_px_q[0];
  assign pix_o.green_out    = out_px_q[1];
  assign pix_o.blue_out     = out_px_q[2];
  assign pix_o.alpha_out    = out_px_q[3];
  assign pix_o.end_of_row   = out_eor_q;
  assign pix_o.end_of_image = out_eoi_q;
endmodule

>>> hw/rtl/mipmap_box_downsample_2x2_core.sv
// Top level of the 2x2 box-filter mip level generator.
//
//   Port         Dir  Handshake     Contents
//   pix_i        in   valid/ready   start_of_image, four 8-bit source channels
//   pix_o        out  valid/ready   four 8-bit averages, end_of_row, end_of_image
//   cfg_*_i      in   write enable  image_width, image_height, pixel_format
//
// One source pixel is accepted per cycle unless the queue is full; the line-buffer RAM has one
// write and one read port. Output valid rises after a block passes the queue and read stage.
// Reset clears counters, queue and valid flags at once; there is no clearing pass.
// An output stall holds the output register, then the read stage; the two-entry queue keeps
// taking pixels until it is full, and only then does the input stall.
module mipmap_box_downsample_2x2_core #(
  parameter int unsigned MAX_WIDTH = mbd_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mbd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mbd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  mbd_pix_in_if.sink                     pix_i,
  mbd_pix_out_if.source                  pix_o
);
  import mbd_pkg::*;

  localparam int unsigned SLOT_W = line_addr_w(MAX_WIDTH);

  logic              fe_valid, fe_ready, be_valid, be_ready;
  op_flags_t         fe_flags, be_flags;
  logic [SLOT_W-1:0] fe_slot, be_slot;
  sum_quad_t         fe_pair, be_pair;

  mbd_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .SLOT_W   (SLOT_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_i),
    .op_valid_o (fe_valid),
    .op_ready_i (fe_ready),
    .op_flags_o (fe_flags),
    .op_slot_o  (fe_slot),
    .op_pair_o  (fe_pair)
  );

  mbd_op_fifo #(
    .SLOT_W(SLOT_W)
  ) u_op_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fe_valid),
    .push_ready_o(fe_ready),
    .push_flags_i(fe_flags),
    .push_slot_i (fe_slot),
    .push_pair_i (fe_pair),
    .pop_valid_o (be_valid),
    .pop_ready_i (be_ready),
    .pop_flags_o (be_flags),
    .pop_slot_o  (be_slot),
    .pop_pair_o  (be_pair)
  );

  mbd_back #(
    .MAX_WIDTH(MAX_WIDTH),
    .SLOT_W   (SLOT_W)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_valid_i(be_valid),
    .op_ready_o(be_ready),
    .op_flags_i(be_flags),
    .op_slot_i (be_slot),
    .op_pair_i (be_pair),
    .pix_o     (pix_o)
  );
endmodule

>>> hw/rtl/mbd_checker.sv
// Port-level checker for the downsampler, bound to the top level.
`include "mipmap_box_downsample_2x2_core_assert.svh"

module mbd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] red_i,
  input logic [7:0] green_i,
  input logic [7:0] blue_i,
  input logic [7:0] alpha_i,
  input logic       eor_i,
  input logic       eoi_i
);
  logic [33:0] out_payload;
  logic        out_stall;

  assign out_payload = {red_i, green_i, blue_i, alpha_i, eor_i, eoi_i};
  assign out_stall   = out_valid_i && !out_ready_i;

  `MBD_ASSERT(a_out_valid_held, clk_i, rst_ni, out_stall |=> out_valid_i, "output valid dropped while stalled")
  `MBD_ASSERT(a_out_payload_held, clk_i, rst_ni, out_stall |=> $stable(out_payload), "output payload changed while stalled")
  `MBD_ASSERT_ALWAYS(a_no_output_in_reset, clk_i, !rst_ni |-> !out_valid_i, "output valid during reset")
  `MBD_ASSERT(a_eoi_ends_row, clk_i, rst_ni, (out_valid_i && eoi_i) |-> eor_i, "end of image without end of row")
endmodule

bind mipmap_box_downsample_2x2_core mbd_checker u_mbd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(pix_o.valid),
  .out_ready_i(pix_o.ready),
  .red_i      (pix_o.red_out),
  .green_i    (pix_o.green_out),
  .blue_i     (pix_o.blue_out),
  .alpha_i    (pix_o.alpha_out),
  .eor_i      (pix_o.end_of_row),
  .eoi_i      (pix_o.end_of_image)
);

>>> tb/tb.sv
// Self-checking testbench for the 2x2 box-filter mip level generator.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbd_pkg::*;

  localparam int unsigned MAX_W      = MAX_WIDTH_DEFAULT;
  localparam int unsigned LINE_DEPTH = MAX_W / 2;
  localparam int unsigned SETTLE     = 16;

  typedef struct packed {
    logic   soi;
    pixel_t px;
  } src_px_t;

  typedef struct {
    pixel_t avg;
    logic   eor;
    logic   eoi;
  } mip_px_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  mbd_pix_in_if  pix_in ();
  mbd_pix_out_if pix_out ();

  mipmap_box_downsample_2x2_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pix_i       (pix_in),
    .pix_o       (pix_out)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state and its copy of the registers.
  sum_quad_t   line_sums    [LINE_DEPTH];
  bit          line_written [LINE_DEPTH];
  pixel_t      left_px   = '0;
  int unsigned col_cnt   = 0;
  int unsigned row_cnt   = 0;
  int unsigned cfg_width = 2048;
  int unsigned cfg_height = 2048;
  pix_fmt_e    cfg_fmt   = FMT_RGBA;

  src_px_t     source_px_q [$];
  mip_px_t     pending_mip_px [$];
  src_px_t     in_flight;
  mip_px_t     want;

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned mismatches = 0;
  int unsigned sent_px = 0;
  int unsigned checked = 0;
  int unsigned eor_seen = 0;
  int unsigned eoi_seen = 0;
  int unsigned settings = 0;
  int unsigned random_px = 0;

  function automatic int unsigned eff_size(int unsigned v, int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  function automatic void box_average_step(src_px_t it);
    int unsigned w, h, even_w, even_h, col, row, slot, tot;
    sum_quad_t   pair;
    sum_quad_t   above;
    mip_px_t     res;
    w = eff_size(cfg_width, MAX_W);
    h = eff_size(cfg_height, HEIGHT_LIMIT);
    even_w = (w / 2) * 2;
    even_h = (h / 2) * 2;
    if (it.soi) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    col = col_cnt;
    row = row_cnt;
    if (col % 2 == 0) begin
      left_px = it.px;
    end else if (col < even_w && row < even_h) begin
      slot = (col / 2) % LINE_DEPTH;
      for (int k = 0; k < 4; k++) begin
        pair[k] = {1'b0, left_px[k]} + {1'b0, it.px[k]};
      end
      if (row % 2 == 0) begin
        line_sums[slot] = pair;
        line_written[slot] = 1'b1;
      end else begin
        above = line_sums[slot];
        for (int k = 0; k < 4; k++) begin
          tot = above[k] + pair[k];
          res.avg[k] = CH_W'(tot >> 2);
        end
        if (cfg_fmt == FMT_RGB) res.avg[3] = '0;
        res.eor = (col == even_w - 1);
        res.eoi = res.eor && (row == even_h - 1);
        pending_mip_px = {pending_mip_px, res};
      end
    end
    if (col >= w - 1) begin
      col_cnt = 0;
      row_cnt = (row >= h - 1) ? 0 : row + 1;
    end else begin
      col_cnt = col + 1;
    end
  endfunction

  // True when every line entry that the given width reads has been written.
  function automatic bit line_ready(int unsigned w);
    int unsigned half;
    half = eff_size(w, MAX_W) / 2;
    for (int unsigned i = 0; i < half; i++) begin
      if (!line_written[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void add_px(logic soi, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                 logic [7:0] a);
    src_px_t it;
    it.soi = soi;
    it.px  = {a, b, g, r};
    source_px_q = {source_px_q, it};
  endfunction

  function automatic pixel_t rand_pixel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return pixel_t'($urandom);
    endcase
  endfunction

  function automatic void check_field(string name, logic [7:0] exp, logic [7:0] act);
    if (act !== exp) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
      mismatches++;
    end
  endfunction

  // Source side: one transfer per accepted handshake, with random gaps.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pix_in.valid <= 1'b0;
    end else begin
      if (pix_in.valid && pix_in.ready) begin
        box_average_step(in_flight);
        sent_px++;
      end
      if (!pix_in.valid || pix_in.ready) begin
        if (source_px_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          in_flight = source_px_q.pop_front();
          pix_in.valid          <= 1'b1;
          pix_in.start_of_image <= in_flight.soi;
          pix_in.red_in         <= in_flight.px[0];
          pix_in.green_in       <= in_flight.px[1];
          pix_in.blue_in        <= in_flight.px[2];
          pix_in.alpha_in       <= in_flight.px[3];
        end else begin
          pix_in.valid <= 1'b0;
        end
      end
    end
  end

  // Result side: compare each transfer with the oldest prediction.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pix_out.ready <= 1'b0;
    end else begin
      if (pix_out.valid && pix_out.ready) begin
        if (pending_mip_px.size() == 0) begin
          $error("output transfer with no pixel predicted");
          mismatches++;
        end else begin
          want = pending_mip_px.pop_front();
          check_field("red_out", want.avg[0], pix_out.red_out);
          check_field("green_out", want.avg[1], pix_out.green_out);
          check_field("blue_out", want.avg[2], pix_out.blue_out);
          check_field("alpha_out", want.avg[3], pix_out.alpha_out);
          check_field("end_of_row", 8'(want.eor), 8'(pix_out.end_of_row));
          check_field("end_of_image", 8'(want.eoi), 8'(pix_out.end_of_image));
          checked++;
          eor_seen += want.eor;
          eoi_seen += want.eoi;
        end
      end
      pix_out.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  task automatic settle();
    do @(posedge clk_i);
    while (source_px_q.size() != 0 || pix_in.valid || pending_mip_px.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_regs(int unsigned w, int unsigned h, pix_fmt_e f);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_IMAGE_WIDTH;
    cfg_data_i  <= CFG_DATA_W'(w);
    @(posedge clk_i);
    cfg_index_i <= CFG_IMAGE_HEIGHT;
    cfg_data_i  <= CFG_DATA_W'(h);
    @(posedge clk_i);
    cfg_index_i <= CFG_PIXEL_FORMAT;
    cfg_data_i  <= CFG_DATA_W'(f);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_width  = w;
    cfg_height = h;
    cfg_fmt    = f;
    settings++;
  endtask

  task automatic random_phase(int unsigned n_px);
    int unsigned w, h;
    pix_fmt_e    f;
    bit          cont;
    pixel_t      p;
    settle();
    case ($urandom_range(0, 19))
      0:       w = 0;
      1:       w = 4095;
      2:       w = 2047;
      3, 4, 5: w = $urandom_range(11, 40);
      default: w = $urandom_range(1, 10);
    endcase
    case ($urandom_range(0, 19))
      0:       h = 0;
      1:       h = 4095;
      2:       h = 2048;
      3, 4:    h = $urandom_range(9, 20);
      default: h = $urandom_range(1, 8);
    endcase
    f = $urandom_range(0, 1) ? FMT_RGB : FMT_RGBA;
    write_regs(w, h, f);
    // Mid-level continuation is only allowed when no unwritten line entry can be read.
    cont = line_ready(w) && $urandom_range(0, 1);
    for (int unsigned i = 0; i < n_px; i++) begin
      p = rand_pixel();
      add_px((i == 0 && !cont) || $urandom_range(0, 99) < 4, p[0], p[1], p[2], p[3]);
    end
    random_px += n_px;
  endtask

  task automatic extreme_phase(int unsigned w, int unsigned h, pix_fmt_e f);
    pixel_t p;
    settle();
    write_regs(w, h, f);
    for (int unsigned i = 0; i < 128; i++) begin
      p = rand_pixel();
      add_px(i == 0, p[0], p[1], p[2], p[3]);
    end
  endtask

  initial begin
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_index_i           = CFG_IMAGE_WIDTH;
    cfg_data_i            = '0;
    pix_in.valid          = 1'b0;
    pix_in.start_of_image = 1'b0;
    pix_in.red_in         = '0;
    pix_in.green_in       = '0;
    pix_in.blue_in        = '0;
    pix_in.alpha_in       = '0;
    pix_out.ready         = 1'b0;
    src_idle_pct          = 27;
    sink_idle_pct         = 45;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full-scale and truncating blocks in a 4x2 level.
    write_regs(4, 2, FMT_RGBA);
    add_px(1, 8'hff, 8'hff, 8'hff, 8'hff);
    add_px(0, 8'hff, 8'hff, 8'hff, 8'hff);
    add_px(0, 8'h00, 8'h00, 8'h00, 8'h00);
    add_px(0, 8'h01, 8'h01, 8'h01, 8'h01);
    add_px(0, 8'hff, 8'hff, 8'hff, 8'hff);
    add_px(0, 8'hff, 8'hff, 8'hff, 8'hff);
    add_px(0, 8'h01, 8'h01, 8'h01, 8'h01);
    add_px(0, 8'h01, 8'h01, 8'h01, 8'h01);

    // Odd width and height drop the last column and row; RGB clears alpha.
    settle();
    write_regs(3, 3, FMT_RGB);
    for (int unsigned i = 0; i < 9; i++) begin
      add_px(i == 0, 8'(8'h10 * i), 8'(8'hff - i), 8'(37 * i), 8'hff);
    end

    // Zero sizes act as one pixel and never produce output.
    settle();
    write_regs(0, 0, FMT_RGBA);
    add_px(1, 8'h12, 8'h34, 8'h56, 8'h78);
    add_px(0, 8'h9a, 8'hbc, 8'hde, 8'hf0);

    settle();
    write_regs(2, 2, FMT_RGBA);
    add_px(1, 8'haa, 8'haa, 8'haa, 8'haa);
    add_px(0, 8'h55, 8'h55, 8'h55, 8'h55);
    add_px(0, 8'h55, 8'h55, 8'h55, 8'h55);
    add_px(0, 8'haa, 8'haa, 8'haa, 8'haa);

    extreme_phase(4095, 2, FMT_RGBA);
    while (random_px < 340) random_phase($urandom_range(20, 100));

    settle();
    src_idle_pct  = 45;
    sink_idle_pct = 27;
    extreme_phase(2, 4095, FMT_RGB);
    while (random_px < 680) random_phase($urandom_range(20, 100));

    settle();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    while (random_px < 1020) random_phase($urandom_range(20, 100));

    settle();
    repeat (SETTLE) @(posedge clk_i);
    $display("Sent %0d source pixels under %0d register settings, checked %0d results,",
             sent_px, settings, checked);
    $display("%0d of which closed an output row and %0d a whole level.", eor_seen, eoi_seen);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timed out with %0d results still pending.", pending_mip_px.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/mbd_pkg.sv
hw/rtl/mbd_pix_if.sv
hw/rtl/mbd_ram.sv
hw/rtl/mbd_op_fifo.sv
hw/rtl/mbd_front.sv
hw/rtl/mbd_back.sv
hw/rtl/mipmap_box_downsample_2x2_core.sv
hw/rtl/mbd_checker.sv
tb/tb.sv
